// ===== src/isct_pkg.sv =====
package isct_pkg;

    localparam int unsigned DEF_TABLE_DEPTH = 1024;
    localparam int unsigned DEF_PHASE_BITS  = 24;

    // interpolation fraction width (Q0.16)
    localparam int unsigned FRAC_W = 16;

    // 2*pi in Q32 as used when the table is generated
    localparam logic [63:0] TWO_PI_Q32 = 64'd26986075409;

    typedef logic signed [15:0] sample_t;
    typedef logic [FRAC_W-1:0]  frac_t;

    // one Taylor step divisor (2k)(2k+1)
    function automatic logic [63:0] taylor_div(input logic [63:0] val, input int unsigned k);
        logic [63:0] res;
        case (k)
            1: res = val / 64'd6;
            2: res = val / 64'd20;
            3: res = val / 64'd42;
            4: res = val / 64'd72;
            5: res = val / 64'd110;
            6: res = val / 64'd156;
            7: res = val / 64'd210;
            default: res = val / 64'd272;
        endcase
        return res;
    endfunction

    // Table entry idx of a one-cycle sine table of 2**lbits entries, Q1.15.
    // Quarter wave from a truncating Q30 Taylor series, mirrored exactly.
    function automatic sample_t sine_entry(input int unsigned idx, input int unsigned lbits);
        logic [63:0]  n;
        logic [63:0]  qn;
        logic [63:0]  i;
        logic [63:0]  q;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  pos;
        logic [63:0]  neg;
        logic [63:0]  s;
        logic [63:0]  e;
        logic         neg_f;
        sample_t      val;
        int unsigned  k;
        n     = 64'd1 << lbits;
        qn    = n >> 2;
        i     = 64'(idx);
        neg_f = 1'b0;
        if (i <= qn) begin
            q = i;
        end else if (i <= 2 * qn) begin
            q = 2 * qn - i;
        end else if (i <= 3 * qn) begin
            q     = i - 2 * qn;
            neg_f = 1'b1;
        end else begin
            q     = 4 * qn - i;
            neg_f = 1'b1;
        end
        x    = ((q * TWO_PI_Q32) >> lbits) >> 2;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = 64'd0;
        for (k = 1; k <= 8; k++) begin
            term = taylor_div((term * x2) >> 30, k);
            if ((k & 1) != 0) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        s = (pos > neg) ? pos - neg : 64'd0;
        e = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (e > 64'd32767) begin
            e = 64'd32767;
        end
        val = e[15:0];
        return neg_f ? -val : val;
    endfunction

endpackage

// ===== src/isct_rom_bank.sv =====
module isct_rom_bank #(
    parameter int unsigned TABLE_DEPTH = isct_pkg::DEF_TABLE_DEPTH,
    parameter int unsigned BANK        = 0
) (
    input  logic                                  aclk,
    input  logic                                  en,
    input  logic [$clog2(TABLE_DEPTH)-3:0]        addr,
    output isct_pkg::sample_t                     rd_data
);
    import isct_pkg::*;

    localparam int unsigned LBITS      = $clog2(TABLE_DEPTH);
    localparam int unsigned BANK_DEPTH = TABLE_DEPTH / 4;

    // entries 4*k + BANK of the sine table
    sample_t rom_w [BANK_DEPTH];
    sample_t rd_reg;

    for (genvar k = 0; k < BANK_DEPTH; k++) begin : g_rom
        assign rom_w[k] = sine_entry(4 * k + BANK, LBITS);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rd_reg <= rom_w[addr];
        end
    end

    assign rd_data = rd_reg;

endmodule

// ===== src/isct_interp.sv =====
module isct_interp (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  isct_pkg::sample_t pts [4],
    input  isct_pkg::frac_t   t_in,
    output logic              out_valid,
    input  logic              out_ready,
    output isct_pkg::sample_t sample
);
    import isct_pkg::*;

    localparam int unsigned NSTAGE = 5;
    localparam logic signed [57:0] ROUND_HALF = 58'sd1 <<< 32;

    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] en;

    // stage A: Catmull-Rom coefficients
    logic signed [20:0] p0_x, p1_x, p2_x, p3_x;
    logic signed [16:0] a_reg;
    logic signed [19:0] b_reg;
    logic signed [18:0] c_reg;
    sample_t            p1_a_reg;
    frac_t              t_a_reg;
    logic signed [20:0] a_next, b_next, c_next;

    // stage B: v = c*t + b*2^16
    logic signed [16:0] ts_a;
    logic signed [35:0] ct;
    logic signed [37:0] v_reg;
    logic signed [16:0] a_b_reg;
    sample_t            p1_b_reg;
    frac_t              t_b_reg;

    // stage C: u = v*t + a*2^32
    logic signed [16:0] ts_b;
    logic signed [54:0] vt;
    logic signed [55:0] u_reg;
    sample_t            p1_c_reg;
    frac_t              t_c_reg;

    // stage D: w*t
    logic signed [39:0] w;
    logic signed [16:0] ts_c;
    logic signed [56:0] wt_reg;
    sample_t            p1_d_reg;

    // stage E: final sum, shift, saturate
    logic signed [57:0] sum;
    logic signed [24:0] y;
    sample_t            sat;
    sample_t            sample_reg;

    always_comb begin
        en[NSTAGE-1] = !vld_reg[NSTAGE-1] || out_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NSTAGE-1];
    assign sample    = sample_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage A
    always_comb begin
        p0_x   = 21'(pts[0]);
        p1_x   = 21'(pts[1]);
        p2_x   = 21'(pts[2]);
        p3_x   = 21'(pts[3]);
        a_next = p2_x - p0_x;
        b_next = (p0_x <<< 1) - 21'sd5 * p1_x + (p2_x <<< 2) - p3_x;
        c_next = 21'sd3 * (p1_x - p2_x) + p3_x - p0_x;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            a_reg    <= a_next[16:0];
            b_reg    <= b_next[19:0];
            c_reg    <= c_next[18:0];
            p1_a_reg <= pts[1];
            t_a_reg  <= t_in;
        end
    end

    // stage B
    assign ts_a = $signed({1'b0, t_a_reg});
    assign ct   = c_reg * ts_a;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            v_reg    <= 38'(ct) + (38'(b_reg) <<< 16);
            a_b_reg  <= a_reg;
            p1_b_reg <= p1_a_reg;
            t_b_reg  <= t_a_reg;
        end
    end

    // stage C
    assign ts_b = $signed({1'b0, t_b_reg});
    assign vt   = v_reg * ts_b;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            u_reg    <= 56'(vt) + (56'(a_b_reg) <<< 32);
            p1_c_reg <= p1_b_reg;
            t_c_reg  <= t_b_reg;
        end
    end

    // stage D: floor divide by 2^16, then multiply
    assign w    = u_reg[55:16];
    assign ts_c = $signed({1'b0, t_c_reg});

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            wt_reg   <= w * ts_c;
            p1_d_reg <= p1_c_reg;
        end
    end

    // stage E
    always_comb begin
        sum = (58'(p1_d_reg) <<< 33) + 58'(wt_reg) + ROUND_HALF;
        y   = sum[57:33];
        if (y > 25'sd32767) begin
            sat = 16'sh7fff;
        end else if (y < -25'sd32768) begin
            sat = -16'sh8000;
        end else begin
            sat = y[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            sample_reg <= sat;
        end
    end

endmodule

// ===== src/interpolated_sine_cosine_table_core.sv =====
// Interpolated sine/cosine table. Each request carries an unsigned phase in
// turns (PHASE_BITS-bit fraction of one cycle) and a select: 0 gives sine,
// 1 gives cosine (a quarter turn is added, wrapping modulo one cycle). The
// upper log2(TABLE_DEPTH) phase bits pick a table entry; the four entries
// around it (wrapping) feed a Catmull-Rom cubic in the remaining bits,
// taken as a Q0.16 fraction. The result is a saturated Q1.15 sample.
// Throughput is one request per clock while m_ready does not stall it; an
// accepted request passes the input register, table read, then five
// arithmetic stages. The sine table is a ROM generated at elaboration and
// split into four interleaved banks so the four neighbors are fetched in
// one read. Every stage holds under backpressure on m_ready, and bubbles in
// the pipeline are squeezed out, so s_ready stays high while any stage
// ahead is empty. TABLE_DEPTH must be a power of two (16..65536).
module interpolated_sine_cosine_table_core #(
    parameter int unsigned TABLE_DEPTH = isct_pkg::DEF_TABLE_DEPTH,
    parameter int unsigned PHASE_BITS  = isct_pkg::DEF_PHASE_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [PHASE_BITS-1:0]   s_phase,
    input  logic                    s_action,
    output logic                    m_valid,
    input  logic                    m_ready,
    output isct_pkg::sample_t       m_sample
);
    import isct_pkg::*;

    localparam int unsigned LBITS = $clog2(TABLE_DEPTH);
    localparam int unsigned AW    = LBITS - 2;

    // quarter turn for cosine
    localparam logic [PHASE_BITS-1:0] QUARTER = {2'b01, {(PHASE_BITS-2){1'b0}}};

    // stage 1: phase decode
    logic [PHASE_BITS-1:0] ph_adj;
    logic [LBITS-1:0]      idx;
    frac_t                 t_dec;
    logic [LBITS-1:0]      idx_reg;
    frac_t                 t1_reg;
    logic                  v1_reg;
    logic                  en1;

    // stage 2: table read
    logic [LBITS-1:0]      base;
    logic [AW-1:0]         bank_addr [4];
    sample_t               bank_q [4];
    logic [1:0]            base_lo_reg;
    frac_t                 t2_reg;
    logic                  v2_reg;
    logic                  en2;

    // interpolator side
    sample_t               pts [4];
    logic                  ip_ready;

    assign ph_adj = s_phase + (s_action ? QUARTER : '0);

    if (PHASE_BITS > LBITS) begin : g_frac
        localparam int unsigned FBITS = PHASE_BITS - LBITS;
        logic [FBITS+FRAC_W-1:0] frac_ext;
        // align fraction to Q0.16: truncate long, zero-pad short
        assign frac_ext = {ph_adj[FBITS-1:0], {FRAC_W{1'b0}}} >> FBITS;
        assign t_dec    = frac_ext[FRAC_W-1:0];
        assign idx      = ph_adj[PHASE_BITS-1 -: LBITS];
    end else if (PHASE_BITS == LBITS) begin : g_exact
        assign t_dec = '0;
        assign idx   = ph_adj;
    end else begin : g_short
        // phase shorter than the index: shift it up, no fraction
        assign t_dec = '0;
        assign idx   = {ph_adj, {(LBITS-PHASE_BITS){1'b0}}};
    end

    // stall chain: a stage moves when it is empty or the next one moves
    assign en2     = !v2_reg || ip_ready;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= s_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            idx_reg <= idx;
            t1_reg  <= t_dec;
        end
    end

    // Neighbors idx-1 .. idx+2 are four consecutive entries, so each lands
    // in a different bank (entry mod 4). Bank b reads base + r where r is
    // the offset that brings base onto b.
    assign base = idx_reg - LBITS'(1);

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [1:0]       r;
        logic [LBITS-1:0] j;
        assign r            = 2'(b) - base[1:0];
        assign j            = base + LBITS'(r);
        assign bank_addr[b] = j[LBITS-1:2];

        isct_rom_bank #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .BANK        (b)
        ) u_bank (
            .aclk    (aclk),
            .en      (en2),
            .addr    (bank_addr[b]),
            .rd_data (bank_q[b])
        );
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            base_lo_reg <= base[1:0];
            t2_reg      <= t1_reg;
        end
    end

    // put bank outputs back in neighbor order P0..P3
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            pts[k] = bank_q[2'(base_lo_reg + 2'(k))];
        end
    end

    isct_interp u_interp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v2_reg),
        .in_ready  (ip_ready),
        .pts       (pts),
        .t_in      (t2_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .sample    (m_sample)
    );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

    import isct_pkg::*;

    // Widths follow the block's default build.
    localparam int unsigned PHASE_W   = DEF_PHASE_BITS;
    localparam int unsigned ROM_DEPTH = DEF_TABLE_DEPTH;
    localparam int unsigned IDX_W     = $clog2(ROM_DEPTH);
    localparam int unsigned FRAC_BITS = PHASE_W - IDX_W;

    // Select codes carried by s_action.
    localparam logic ACT_SINE   = 1'b0;
    localparam logic ACT_COSINE = 1'b1;

    // 2*pi scaled by 2^32, the constant the ROM is generated with.
    localparam logic [63:0] TURN_Q32 = 64'd26986075409;

    // Drain wait after the last result, with slack beyond the pipeline depth.
    localparam int unsigned TAIL_CYCLES = 16;

    // Cap on the whole run, several times the slowest legal run.
    localparam int unsigned RUN_LIMIT_NS = 4_000_000;

    // ------------------------------------------------------------------
    // Scoreboard: predicts the sample for each accepted request and
    // checks results in order against it.
    // ------------------------------------------------------------------
    class sine_scoreboard;
        int      sine_rom [ROM_DEPTH];
        sample_t expected_samples [$];
        int unsigned failures;

        function new();
            failures = 0;
            build_rom();
        endfunction

        // Quarter-wave value from a truncating Q30 Taylor series.
        function int quarter_value(longint unsigned q);
            logic [63:0] x;
            logic [63:0] x2;
            logic [63:0] term;
            logic [63:0] plus;
            logic [63:0] minus;
            logic [63:0] mag;
            logic [63:0] rounded;
            x     = ((64'(q) * TURN_Q32) / 64'(ROM_DEPTH)) >> 2;
            x2    = (x * x) >> 30;
            term  = x;
            plus  = x;
            minus = 64'd0;
            for (int k = 1; k <= 8; k++) begin
                term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    minus = minus + term;
                end else begin
                    plus = plus + term;
                end
            end
            mag     = (plus > minus) ? plus - minus : 64'd0;
            rounded = (mag * 64'd32767 + (64'd1 << 29)) >> 30;
            if (rounded > 64'd32767) begin
                rounded = 64'd32767;
            end
            return int'(rounded);
        endfunction

        // One full cycle, built from a quarter wave mirrored exactly.
        function void build_rom();
            int unsigned quarter;
            int unsigned q;
            bit          flip;
            quarter = ROM_DEPTH / 4;
            for (int unsigned i = 0; i < ROM_DEPTH; i++) begin
                flip = 1'b0;
                if (i <= quarter) begin
                    q = i;
                end else if (i <= 2 * quarter) begin
                    q = 2 * quarter - i;
                end else if (i <= 3 * quarter) begin
                    q    = i - 2 * quarter;
                    flip = 1'b1;
                end else begin
                    q    = 4 * quarter - i;
                    flip = 1'b1;
                end
                sine_rom[i] = flip ? -quarter_value(q) : quarter_value(q);
            end
        endfunction

        // Catmull-Rom interpolation between neighboring ROM entries.
        function sample_t interpolate(logic [PHASE_W-1:0] phase, logic action);
            logic [PHASE_W-1:0] turn;
            logic [IDX_W-1:0]   idx;
            logic [63:0]        frac;
            longint             t;
            longint             p0;
            longint             p1;
            longint             p2;
            longint             p3;
            longint             a;
            longint             b;
            longint             c;
            longint             v;
            longint             u;
            longint             w;
            longint             y;
            turn = phase;
            if (action == ACT_COSINE) begin
                turn = turn + (PHASE_W'(1) << (PHASE_W - 2));
            end
            idx  = turn[PHASE_W-1 -: IDX_W];
            frac = 64'(turn) & ((64'd1 << FRAC_BITS) - 64'd1);
            // fraction rescaled to Q0.16: truncate or zero-pad
            t  = longint'((frac << 16) >> FRAC_BITS);
            p0 = sine_rom[IDX_W'(idx - 1)];
            p1 = sine_rom[idx];
            p2 = sine_rom[IDX_W'(idx + 1)];
            p3 = sine_rom[IDX_W'(idx + 2)];
            a  = p2 - p0;
            b  = 2 * p0 - 5 * p1 + 4 * p2 - p3;
            c  = 3 * (p1 - p2) + p3 - p0;
            v  = c * t + b * 64'sd65536;
            u  = v * t + a * 64'sd4294967296;
            w  = u >>> 16;
            y  = (p1 * 64'sd8589934592 + w * t + 64'sd4294967296) >>> 33;
            if (y > 32767) begin
                y = 32767;
            end
            if (y < -32768) begin
                y = -32768;
            end
            return sample_t'(y);
        endfunction

        function void note_request(logic [PHASE_W-1:0] phase, logic action);
            expected_samples.push_back(interpolate(phase, action));
        endfunction

        function void check_sample(sample_t got);
            sample_t want;
            if (expected_samples.size() == 0) begin
                $display("%0t: sample %0d with no request pending", $time, got);
                failures++;
            end else begin
                want = expected_samples.pop_front();
                if (got !== want) begin
                    $display("%0t: sample mismatch, expected %0d, actual %0d",
                             $time, want, got);
                    failures++;
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero.
    // ------------------------------------------------------------------
    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_valid  = 1'b0;
    logic [PHASE_W-1:0] s_phase  = '0;
    logic               s_action = ACT_SINE;
    logic               m_ready  = 1'b0;
    logic               s_ready;
    logic               m_valid;
    sample_t            m_sample;

    // Idle/stall rates in percent, changed per traffic phase.
    int unsigned        sender_idle_pct = 0;
    int unsigned        receiver_stall_pct = 0;

    sine_scoreboard     sb;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    interpolated_sine_cosine_table_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_phase  (s_phase),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_sample (m_sample)
    );

    // Result side: ready drops at random per the current stall rate.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Both handshakes are seen with the values from just before the edge,
    // so ordering within the time step does not matter.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_sample(m_sample);
            end
            if (s_valid && s_ready) begin
                sb.note_request(s_phase, s_action);
            end
        end
    end

    // Present one request and hold it until taken. Optional idle cycles
    // before it follow the sender idle rate.
    task automatic send_request(input logic [PHASE_W-1:0] phase, input logic action);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_phase  <= phase;
        s_action <= action;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    // Sender holds off until every outstanding request has its result.
    // One edge first so the last accepted request is already queued.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (sb.expected_samples.size() != 0);
    endtask

    // Random phase, a quarter of the time steered onto the quadrant
    // boundaries and table wrap where the neighbor fetch is interesting.
    function automatic logic [PHASE_W-1:0] random_phase();
        int unsigned            corners [13] = '{0, 1, 2, 255, 256, 257, 511, 512,
                                                 513, 767, 768, 1022, 1023};
        logic [IDX_W-1:0]       idx;
        logic [FRAC_BITS-1:0]   frac;
        logic [PHASE_W-1:0]     phase;
        phase = PHASE_W'($urandom());
        if ($urandom_range(3) == 0) begin
            idx = IDX_W'(corners[$urandom_range(12)]);
            case ($urandom_range(3))
                0: frac = '0;
                1: frac = '1;
                default: frac = FRAC_BITS'($urandom());
            endcase
            phase = {idx, frac};
        end
        return phase;
    endfunction

    // Main sequence.
    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests: field extremes, both selects, cosine offset
        // wrapping past a full turn, table index wrap on both sides,
        // fraction extremes, and the peaks where overshoot may saturate.
        send_request(24'h000000, ACT_SINE);
        send_request(24'h000000, ACT_COSINE);
        send_request(24'hFFFFFF, ACT_SINE);
        send_request(24'hFFFFFF, ACT_COSINE);
        send_request(24'hC00000, ACT_COSINE);
        send_request(24'hBFFFFF, ACT_COSINE);
        send_request(24'hFFC000, ACT_SINE);
        send_request(24'hFF8000, ACT_SINE);
        send_request(24'hFFBFFF, ACT_SINE);
        send_request(24'h004000, ACT_SINE);
        send_request(24'h003FFF, ACT_SINE);
        send_request(24'h002000, ACT_SINE);
        send_request(24'h3FFFFF, ACT_SINE);
        send_request(24'h400000, ACT_SINE);
        send_request(24'h400000, ACT_COSINE);
        send_request(24'h3FE000, ACT_SINE);
        send_request(24'h402000, ACT_SINE);
        send_request(24'hC02000, ACT_SINE);
        send_request(24'hBFE000, ACT_SINE);
        send_request(24'h7FFFFF, ACT_SINE);
        send_request(24'h800000, ACT_COSINE);
        send_request(24'h555555, ACT_SINE);
        send_request(24'hAAAAAA, ACT_COSINE);
        wait_for_drain();

        // Random traffic in four phases of idling: none, sender idle,
        // receiver stalling, both. Drain between phases.
        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 77;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 77;
                end
                default: begin
                    sender_idle_pct    = 18;
                    receiver_stall_pct = 18;
                end
            endcase
            for (int n = 0; n < 312; n++) begin
                send_request(random_phase(), $urandom_range(1) ? ACT_COSINE : ACT_SINE);
                // occasional extra burst of eight sine requests inside idling phases
                if (mode != 0 && $urandom_range(99) == 0) begin
                    for (int r = 0; r < 8; r++) begin
                        send_request(PHASE_W'($urandom()), ACT_SINE);
                    end
                end
            end
            wait_for_drain();
        end

        receiver_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (sb.expected_samples.size() != 0) begin
            $display("%0t: %0d samples never arrived", $time, sb.expected_samples.size());
            sb.failures++;
        end
        if (sb.failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog on the whole run.
    initial begin
        #(RUN_LIMIT_NS);
        $display("%0t: run timed out", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
